// ----- rtl/pip_pkg.sv -----
package pip_pkg;

  // Sizes
  localparam int unsigned MaxVertices = 64;
  localparam int unsigned CoordWidth  = 32;
  localparam int unsigned FieldWidth  = 32;
  localparam int unsigned ModeWidth   = 2;
  localparam int unsigned CountWidth  = $clog2(MaxVertices + 1);
  localparam int unsigned DiffWidth   = CoordWidth + 1;
  localparam int unsigned MagWidth    = CoordWidth;
  localparam int unsigned ProdWidth   = 2 * MagWidth;
  localparam int unsigned SvalWidth   = ProdWidth + 1;

  // Item modes
  localparam logic [ModeWidth-1:0] ModeAppend = 2'd0;
  localparam logic [ModeWidth-1:0] ModeTest   = 2'd1;
  localparam logic [ModeWidth-1:0] ModeClear  = 2'd2;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [DiffWidth-1:0]  diff_t;
  typedef logic        [MagWidth-1:0]   mag_t;
  typedef logic        [ProdWidth-1:0]  prod_t;
  typedef logic signed [SvalWidth-1:0]  sval_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vertex_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic append;
    logic rotate;
    logic last;
  } cell_ctrl_t;

  // One edge handed to the crossing pipeline
  typedef struct packed {
    logic    valid;
    vertex_t a;
    vertex_t b;
    vertex_t p;
  } edge_req_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } edge_res_t;

  // Sign-extended difference a - b
  function automatic diff_t sub_ext(coord_t a, coord_t b);
    diff_t ea;
    diff_t eb;
    ea = {a[CoordWidth-1], a};
    eb = {b[CoordWidth-1], b};
    return ea - eb;
  endfunction

  // Magnitude of a difference; always fits in CoordWidth bits
  function automatic mag_t abs_mag(diff_t d);
    diff_t neg;
    neg = -d;
    return d[DiffWidth-1] ? neg[MagWidth-1:0] : d[MagWidth-1:0];
  endfunction

endpackage

// ----- rtl/pip_if.sv -----
interface pip_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [pip_pkg::ModeWidth-1:0]         mode;
  logic signed [pip_pkg::FieldWidth-1:0] coord_x;
  logic signed [pip_pkg::FieldWidth-1:0] coord_y;

  modport source (output valid, output mode, output coord_x, output coord_y, input ready);
  modport sink (input valid, input mode, input coord_x, input coord_y, output ready);
endinterface

interface pip_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic overflowed;

  modport source (output valid, output inside_res, output overflowed, input ready);
  modport sink (input valid, input inside_res, input overflowed, output ready);
endinterface

// ----- rtl/pip_cell.sv -----
module pip_cell (
  input  logic                clk_i,
  input  pip_pkg::cell_ctrl_t ctrl_i,
  input  pip_pkg::vertex_t    prev_i,
  input  pip_pkg::vertex_t    next_i,
  input  pip_pkg::vertex_t    head_i,
  output pip_pkg::vertex_t    vtx_o
);

  pip_pkg::vertex_t vtx_d;
  pip_pkg::vertex_t vtx_q;

  // Shift in on append, rotate toward the head on a query walk
  always_comb begin
    vtx_d = vtx_q;
    if (ctrl_i.append) begin
      vtx_d = prev_i;
    end else if (ctrl_i.rotate) begin
      vtx_d = ctrl_i.last ? head_i : next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    vtx_q <= vtx_d;
  end

  assign vtx_o = vtx_q;

endmodule

// ----- rtl/pip_edge_pipe.sv -----
module pip_edge_pipe (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pip_pkg::edge_req_t  edge_i,
  output pip_pkg::edge_res_t  res_o,
  output logic                busy_o
);

  typedef struct packed {
    logic           straddle;
    pip_pkg::diff_t d_px_ax;
    pip_pkg::diff_t d_by_ay;
    pip_pkg::diff_t d_bx_ax;
    pip_pkg::diff_t d_py_ay;
  } diff_stage_t;

  typedef struct packed {
    logic          straddle;
    logic          dy_pos;
    logic          l_neg;
    logic          r_neg;
    pip_pkg::mag_t m_px_ax;
    pip_pkg::mag_t m_by_ay;
    pip_pkg::mag_t m_bx_ax;
    pip_pkg::mag_t m_py_ay;
  } mag_stage_t;

  typedef struct packed {
    logic           straddle;
    logic           dy_pos;
    logic           l_neg;
    logic           r_neg;
    pip_pkg::prod_t l_prod;
    pip_pkg::prod_t r_prod;
  } prod_stage_t;

  typedef struct packed {
    logic           straddle;
    logic           dy_pos;
    pip_pkg::sval_t l_val;
    pip_pkg::sval_t r_val;
  } sval_stage_t;

  logic        v1_q, v2_q, v3_q, v4_q, v5_q;
  diff_stage_t s1_d, s1_q;
  mag_stage_t  s2_d, s2_q;
  prod_stage_t s3_d, s3_q;
  sval_stage_t s4_d, s4_q;
  logic        hit_d, hit_q;
  pip_pkg::sval_t l_pos, r_pos;

  // Stage 1: straddle test and coordinate differences
  always_comb begin
    s1_d.straddle = (edge_i.a.y > edge_i.p.y) != (edge_i.b.y > edge_i.p.y);
    s1_d.d_px_ax  = pip_pkg::sub_ext(edge_i.p.x, edge_i.a.x);
    s1_d.d_by_ay  = pip_pkg::sub_ext(edge_i.b.y, edge_i.a.y);
    s1_d.d_bx_ax  = pip_pkg::sub_ext(edge_i.b.x, edge_i.a.x);
    s1_d.d_py_ay  = pip_pkg::sub_ext(edge_i.p.y, edge_i.a.y);
  end

  // Stage 2: split into magnitude and sign
  always_comb begin
    s2_d.straddle = s1_q.straddle;
    s2_d.dy_pos   = !s1_q.d_by_ay[pip_pkg::DiffWidth-1] && (s1_q.d_by_ay != '0);
    s2_d.l_neg    = s1_q.d_px_ax[pip_pkg::DiffWidth-1] ^ s1_q.d_by_ay[pip_pkg::DiffWidth-1];
    s2_d.r_neg    = s1_q.d_bx_ax[pip_pkg::DiffWidth-1] ^ s1_q.d_py_ay[pip_pkg::DiffWidth-1];
    s2_d.m_px_ax  = pip_pkg::abs_mag(s1_q.d_px_ax);
    s2_d.m_by_ay  = pip_pkg::abs_mag(s1_q.d_by_ay);
    s2_d.m_bx_ax  = pip_pkg::abs_mag(s1_q.d_bx_ax);
    s2_d.m_py_ay  = pip_pkg::abs_mag(s1_q.d_py_ay);
  end

  // Stage 3: two unsigned magnitude products
  always_comb begin
    s3_d.straddle = s2_q.straddle;
    s3_d.dy_pos   = s2_q.dy_pos;
    s3_d.l_neg    = s2_q.l_neg;
    s3_d.r_neg    = s2_q.r_neg;
    s3_d.l_prod   = s2_q.m_px_ax * s2_q.m_by_ay;
    s3_d.r_prod   = s2_q.m_bx_ax * s2_q.m_py_ay;
  end

  // Stage 4: restore the product signs
  always_comb begin
    l_pos         = {1'b0, s3_q.l_prod};
    r_pos         = {1'b0, s3_q.r_prod};
    s4_d.straddle = s3_q.straddle;
    s4_d.dy_pos   = s3_q.dy_pos;
    s4_d.l_val    = s3_q.l_neg ? -l_pos : l_pos;
    s4_d.r_val    = s3_q.r_neg ? -r_pos : r_pos;
  end

  // Stage 5: sign-corrected compare gives the crossing
  always_comb begin
    hit_d = s4_q.straddle &&
            (s4_q.dy_pos ? (s4_q.l_val < s4_q.r_val) : (s4_q.r_val < s4_q.l_val));
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= edge_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    s2_q  <= s2_d;
    s3_q  <= s3_d;
    s4_q  <= s4_d;
    hit_q <= hit_d;
  end

  assign res_o.valid = v5_q;
  assign res_o.hit   = hit_q;
  assign busy_o      = v1_q | v2_q | v3_q | v4_q | v5_q;

endmodule

// ----- rtl/point_in_polygon_crossing_test_unit.sv -----
// Append and clear items leave the unit idle, so a new item can be taken the next cycle.
// A test item walks the N stored vertices (N <= 64) by rotating the cell chain,
// one edge per cycle, through a five-stage crossing pipeline, then waits for the
// pipeline to drain and for the output register to be free (an empty polygon
// skips the walk); no new item is taken until the result is loaded.
// A waiting result does not block appends or clears; it only holds the end of
// the next query until the result transfers.
// Reset clears the vertex count, the dropped flag and all control; the cell
// contents stay undefined until written.
module point_in_polygon_crossing_test_unit (
  input  logic clk_i,
  input  logic rst_ni,
  pip_in_if.sink    in_i,
  pip_out_if.source out_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRun   = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  localparam int unsigned NumCells = pip_pkg::MaxVertices;
  localparam int unsigned CntW     = pip_pkg::CountWidth;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] n_q, n_d;
  logic [CntW-1:0] edge_cnt_q, edge_cnt_d;
  logic            dropped_q, dropped_d;
  logic            parity_q, parity_d;
  logic            out_valid_q, out_valid_d;
  logic            inside_q, inside_d;
  logic            ovf_q, ovf_d;
  pip_pkg::vertex_t pt_q, pt_d;

  logic             in_fire;
  logic             do_append;
  logic             do_rotate;
  logic             pipe_busy;
  pip_pkg::vertex_t new_vtx;
  pip_pkg::vertex_t cell_vtx [NumCells];
  pip_pkg::edge_req_t edge_req;
  pip_pkg::edge_res_t edge_res;

  assign in_i.ready = (state_q == StIdle);
  assign in_fire    = in_i.valid && in_i.ready;

  assign new_vtx.x = in_i.coord_x[pip_pkg::CoordWidth-1:0];
  assign new_vtx.y = in_i.coord_y[pip_pkg::CoordWidth-1:0];

  assign do_append = in_fire && (in_i.mode == pip_pkg::ModeAppend) &&
                     (count_q < CntW'(NumCells));
  assign do_rotate = (state_q == StRun);

  // Vertex cell chain: newest vertex at the head
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    pip_pkg::cell_ctrl_t ctrl;
    pip_pkg::vertex_t    prev_v;
    pip_pkg::vertex_t    next_v;

    assign ctrl.append = do_append;
    assign ctrl.rotate = do_rotate && (CntW'(k) < n_q);
    assign ctrl.last   = (n_q == CntW'(k + 1));

    if (k == 0) begin : g_head
      assign prev_v = new_vtx;
    end else begin : g_body
      assign prev_v = cell_vtx[k-1];
    end

    if (k == NumCells - 1) begin : g_tail
      assign next_v = cell_vtx[0];
    end else begin : g_mid
      assign next_v = cell_vtx[k+1];
    end

    pip_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .prev_i (prev_v),
      .next_i (next_v),
      .head_i (cell_vtx[0]),
      .vtx_o  (cell_vtx[k])
    );
  end

  // Edge at the head of the chain; a single vertex pairs with itself
  always_comb begin
    edge_req.valid = do_rotate;
    edge_req.a     = cell_vtx[0];
    edge_req.b     = (n_q == CntW'(1)) ? cell_vtx[0] : cell_vtx[1];
    edge_req.p     = pt_q;
  end

  pip_edge_pipe u_edge_pipe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .edge_i (edge_req),
    .res_o  (edge_res),
    .busy_o (pipe_busy)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    n_d         = n_q;
    edge_cnt_d  = edge_cnt_q;
    dropped_d   = dropped_q;
    parity_d    = parity_q ^ (edge_res.valid && edge_res.hit);
    pt_d        = pt_q;
    out_valid_d = out_valid_q && !out_o.ready;
    inside_d    = inside_q;
    ovf_d       = ovf_q;

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          case (in_i.mode)
            pip_pkg::ModeAppend: begin
              if (do_append) begin
                count_d = count_q + CntW'(1);
              end else begin
                dropped_d = 1'b1;
              end
            end
            pip_pkg::ModeClear: begin
              count_d   = '0;
              dropped_d = 1'b0;
            end
            pip_pkg::ModeTest: begin
              pt_d       = new_vtx;
              n_d        = count_q;
              edge_cnt_d = '0;
              parity_d   = 1'b0;
              state_d    = (count_q == '0) ? StDrain : StRun;
            end
            default: begin
            end
          endcase
        end
      end
      StRun: begin
        edge_cnt_d = edge_cnt_q + CntW'(1);
        if (edge_cnt_q == n_q - CntW'(1)) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (!pipe_busy) begin
          state_d = StDone;
        end
      end
      StDone: begin
        // Hold until the output register is free
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          inside_d    = parity_q;
          ovf_d       = dropped_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      n_q         <= '0;
      edge_cnt_q  <= '0;
      dropped_q   <= 1'b0;
      parity_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      n_q         <= n_d;
      edge_cnt_q  <= edge_cnt_d;
      dropped_q   <= dropped_d;
      parity_q    <= parity_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pt_q     <= pt_d;
    inside_q <= inside_d;
    ovf_q    <= ovf_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.inside_res = inside_q;
  assign out_o.overflowed = ovf_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(NumCells))
    else $error("vertex count beyond capacity");

  a_drop_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(dropped_q) |-> $past(count_q) == CntW'(NumCells))
    else $error("dropped flag set below capacity");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRun |-> edge_cnt_q < n_q)
    else $error("edge walk past vertex count");

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle |-> !pipe_busy)
    else $error("crossing pipeline busy while idle");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == StDone)
    else $error("result raised outside completion");

endmodule
